// ===== rtl/mbp_pkg.sv =====
package mbp_pkg;

   localparam int MAX_HISTORY_DEF = 64;
   localparam int MAX_HIDDEN_DEF  = 16;
   localparam int WEIGHT_BITS_DEF = 16;

   localparam int NEURON_IDX_W = 6;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 32;

   typedef enum logic [2:0] {
      OP_PREDICT    = 3'd0,
      OP_HIST_UPD   = 3'd1,
      OP_WR_HWEIGHT = 3'd2,
      OP_WR_HBIAS   = 3'd3,
      OP_WR_OWEIGHT = 3'd4
   } opcode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_HIST_LEN   = 2'd0,
      CSR_HIDDEN_CNT = 2'd1,
      CSR_OUT_BIAS   = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                    hist_upd;
      logic                    wr_hweight;
      logic                    wr_hbias;
      logic                    wr_oweight;
      logic                    start;
      logic                    issue;
      logic [NEURON_IDX_W-1:0] issue_idx;
      logic                    finish;
   } cmd_type;

   typedef struct packed {
      logic                    busy;
      logic [NEURON_IDX_W-1:0] last_idx;
   } status_type;

   localparam logic [7:0] SIG_ROM [256] = '{
      8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
      8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
      8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
      8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1, 8'd1, 8'd1,
      8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1,
      8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd2, 8'd2,
      8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd3,
      8'd3, 8'd3, 8'd3, 8'd3, 8'd4, 8'd4, 8'd4, 8'd4,
      8'd5, 8'd5, 8'd5, 8'd6, 8'd6, 8'd6, 8'd7, 8'd7,
      8'd8, 8'd8, 8'd8, 8'd9, 8'd10, 8'd10, 8'd11, 8'd11,
      8'd12, 8'd13, 8'd14, 8'd15, 8'd15, 8'd16, 8'd17, 8'd18,
      8'd19, 8'd21, 8'd22, 8'd23, 8'd24, 8'd26, 8'd27, 8'd29,
      8'd31, 8'd32, 8'd34, 8'd36, 8'd38, 8'd40, 8'd42, 8'd44,
      8'd47, 8'd49, 8'd52, 8'd54, 8'd57, 8'd60, 8'd63, 8'd66,
      8'd69, 8'd72, 8'd75, 8'd79, 8'd82, 8'd86, 8'd89, 8'd93,
      8'd97, 8'd100, 8'd104, 8'd108, 8'd112, 8'd116, 8'd120, 8'd124,
      8'd128, 8'd132, 8'd136, 8'd140, 8'd144, 8'd148, 8'd152, 8'd156,
      8'd159, 8'd163, 8'd167, 8'd170, 8'd174, 8'd177, 8'd181, 8'd184,
      8'd187, 8'd190, 8'd193, 8'd196, 8'd199, 8'd202, 8'd204, 8'd207,
      8'd209, 8'd212, 8'd214, 8'd216, 8'd218, 8'd220, 8'd222, 8'd224,
      8'd225, 8'd227, 8'd229, 8'd230, 8'd232, 8'd233, 8'd234, 8'd235,
      8'd237, 8'd238, 8'd239, 8'd240, 8'd241, 8'd241, 8'd242, 8'd243,
      8'd244, 8'd245, 8'd245, 8'd246, 8'd246, 8'd247, 8'd248, 8'd248,
      8'd248, 8'd249, 8'd249, 8'd250, 8'd250, 8'd250, 8'd251, 8'd251,
      8'd251, 8'd252, 8'd252, 8'd252, 8'd252, 8'd253, 8'd253, 8'd253,
      8'd253, 8'd253, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254, 8'd254,
      8'd254, 8'd254, 8'd254, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
      8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
      8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
      8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
      8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
      8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255
   };

endpackage

// ===== rtl/mbp_ram.sv =====
module mbp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                      wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                      rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/mbp_ctrl.sv =====
module mbp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [2:0]          req_opcode,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output mbp_pkg::cmd_type    cmd,
   input  mbp_pkg::status_type stat
);
   import mbp_pkg::*;

   state_type                state_ff, state_in;
   logic [NEURON_IDX_W-1:0]  cnt_ff, cnt_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      cmd.issue_idx = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_opcode)
                  OP_PREDICT: begin
                     cmd.start = 1'b1;
                     cnt_in    = '0;
                     state_in  = ST_RUN;
                  end
                  OP_HIST_UPD:   cmd.hist_upd   = 1'b1;
                  OP_WR_HWEIGHT: cmd.wr_hweight = 1'b1;
                  OP_WR_HBIAS:   cmd.wr_hbias   = 1'b1;
                  OP_WR_OWEIGHT: cmd.wr_oweight = 1'b1;
                  default: ;
               endcase
            end
         end
         ST_RUN: begin
            cmd.issue = 1'b1;
            if (cnt_ff == stat.last_idx) begin
               state_in = ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (!stat.busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ===== rtl/mbp_datapath.sv =====
module mbp_datapath #(
   parameter int MAX_HISTORY = 64,
   parameter int MAX_HIDDEN  = 16,
   parameter int WEIGHT_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  mbp_pkg::cmd_type                     cmd,
   output mbp_pkg::status_type                  stat,
   input  logic                                 csr_we,
   input  logic [mbp_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [mbp_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic                                 req_taken,
   input  logic [3:0]                           req_neuron,
   input  logic [5:0]                           req_input_index,
   input  logic signed [15:0]                   req_weight_value,
   output logic                                 rsp_predict_taken,
   output logic signed [31:0]                   rsp_score
);
   import mbp_pkg::*;

   localparam int NW     = (MAX_HIDDEN > 1) ? $clog2(MAX_HIDDEN) : 1;
   localparam int WB     = WEIGHT_BITS;
   localparam int NG     = (MAX_HISTORY + 7) / 8;
   localparam int PART_W = WB + 3;
   localparam int SUM_W  = WB + 8;
   localparam int PROD_W = WB + 9;
   localparam int ACC_W  = ((WB + 13 > 31) ? WB + 13 : 31) + 2;

   logic [6:0]              hist_len_ff;
   logic [4:0]              hid_cnt_ff;
   logic signed [31:0]      out_bias_ff;
   logic [MAX_HISTORY-1:0]  hist_ff, hist_in;
   logic [MAX_HISTORY-1:0]  len_mask;
   logic [6:0]              hl_eff;

   logic signed [WB-1:0]    wv;
   logic                    neuron_ok;
   logic                    index_ok;
   logic [NW-1:0]           waddr;
   logic [NW-1:0]           raddr;

   logic [WB-1:0]           lane_rd [MAX_HISTORY];
   logic signed [WB-1:0]    lane_w [NG*8];
   logic                    lane_m [NG*8];
   logic [WB-1:0]           hbias_rd;
   logic [WB-1:0]           oweight_rd;

   logic [3:0]                  v_ff;
   logic signed [PART_W-1:0]    part_ff [NG];
   logic signed [PART_W-1:0]    part_in [NG];
   logic signed [WB-1:0]        bias_a_ff;
   logic signed [WB-1:0]        ow_a_ff;
   logic signed [SUM_W-1:0]     sum_b;
   logic signed [11:0]          clamp_b;
   logic [7:0]                  act_ff;
   logic signed [WB-1:0]        ow_b_ff;
   logic signed [PROD_W-1:0]    prod_ff;
   logic signed [ACC_W-1:0]     acc_ff;
   logic signed [31:0]          score_ff;
   logic signed [31:0]          score_sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_len_ff <= 7'd64;
         hid_cnt_ff  <= 5'd16;
         out_bias_ff <= '0;
         hist_ff     <= '0;
         v_ff        <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_HIST_LEN:   hist_len_ff <= csr_wdata[6:0];
               CSR_HIDDEN_CNT: hid_cnt_ff  <= csr_wdata[4:0];
               CSR_OUT_BIAS:   out_bias_ff <= csr_wdata;
               default: ;
            endcase
         end
         hist_ff <= hist_in;
         v_ff    <= {v_ff[2:0], cmd.issue};
      end
   end

   always_comb begin
      if (hist_len_ff == 7'd0) begin
         hl_eff = 7'd1;
      end else if (int'(hist_len_ff) > MAX_HISTORY) begin
         hl_eff = 7'(MAX_HISTORY);
      end else begin
         hl_eff = hist_len_ff;
      end
      for (int j = 0; j < MAX_HISTORY; j++) begin
         len_mask[j] = (7'(j) < hl_eff);
      end
   end

   always_comb begin
      stat.busy = |v_ff;
      if (hid_cnt_ff == 5'd0) begin
         stat.last_idx = '0;
      end else if (int'(hid_cnt_ff) > MAX_HIDDEN) begin
         stat.last_idx = NEURON_IDX_W'(MAX_HIDDEN - 1);
      end else begin
         stat.last_idx = NEURON_IDX_W'(hid_cnt_ff - 5'd1);
      end
   end

   assign hist_in = cmd.hist_upd ?
                    (((hist_ff << 1) | MAX_HISTORY'(req_taken)) & len_mask) : hist_ff;

   assign wv        = WB'(req_weight_value);
   assign neuron_ok = (int'(req_neuron) < MAX_HIDDEN);
   assign index_ok  = (int'(req_input_index) < MAX_HISTORY);
   assign waddr     = NW'(req_neuron);
   assign raddr     = NW'(cmd.issue_idx);

   for (genvar j = 0; j < MAX_HISTORY; j++) begin : g_lane
      mbp_ram #(.WIDTH(WB), .DEPTH(MAX_HIDDEN)) u_hw_ram (
         .clock (clock),
         .we    (cmd.wr_hweight && neuron_ok && index_ok && (int'(req_input_index) == j)),
         .waddr (waddr),
         .wdata (wv),
         .raddr (raddr),
         .rdata (lane_rd[j])
      );
   end

   for (genvar j = 0; j < NG*8; j++) begin : g_pad
      if (j < MAX_HISTORY) begin : g_real
         assign lane_w[j] = signed'(lane_rd[j]);
         assign lane_m[j] = hist_ff[j] && len_mask[j];
      end else begin : g_zero
         assign lane_w[j] = '0;
         assign lane_m[j] = 1'b0;
      end
   end

   mbp_ram #(.WIDTH(WB), .DEPTH(MAX_HIDDEN)) u_hbias_ram (
      .clock (clock),
      .we    (cmd.wr_hbias && neuron_ok),
      .waddr (waddr),
      .wdata (wv),
      .raddr (raddr),
      .rdata (hbias_rd)
   );

   mbp_ram #(.WIDTH(WB), .DEPTH(MAX_HIDDEN)) u_oweight_ram (
      .clock (clock),
      .we    (cmd.wr_oweight && neuron_ok),
      .waddr (waddr),
      .wdata (wv),
      .raddr (raddr),
      .rdata (oweight_rd)
   );

   // stage A: masked partial sums, eight lanes per group
   always_comb begin
      for (int g = 0; g < NG; g++) begin
         part_in[g] = '0;
         for (int k = 0; k < 8; k++) begin
            if (lane_m[g*8+k]) begin
               part_in[g] = part_in[g] + PART_W'(lane_w[g*8+k]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int g = 0; g < NG; g++) begin
         part_ff[g] <= part_in[g];
      end
      bias_a_ff <= signed'(hbias_rd);
      ow_a_ff   <= signed'(oweight_rd);
   end

   // stage B: neuron sum, clamp to [-8,8) and sigmoid lookup
   always_comb begin
      sum_b = SUM_W'(bias_a_ff);
      for (int g = 0; g < NG; g++) begin
         sum_b = sum_b + SUM_W'(part_ff[g]);
      end
      if (sum_b < -SUM_W'(2048)) begin
         clamp_b = -12'sd2048;
      end else if (sum_b > SUM_W'(2047)) begin
         clamp_b = 12'sd2047;
      end else begin
         clamp_b = sum_b[11:0];
      end
   end

   always_ff @(posedge clock) begin
      act_ff  <= SIG_ROM[{~clamp_b[11], clamp_b[10:4]}];
      ow_b_ff <= ow_a_ff;
      prod_ff <= signed'({1'b0, act_ff}) * ow_b_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         acc_ff <= ACC_W'(out_bias_ff);
      end else if (v_ff[3]) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
      if (cmd.finish) begin
         score_ff <= score_sat;
      end
   end

   always_comb begin
      if ((&acc_ff[ACC_W-1:31]) || !(|acc_ff[ACC_W-1:31])) begin
         score_sat = acc_ff[31:0];
      end else if (acc_ff[ACC_W-1]) begin
         score_sat = 32'sh8000_0000;
      end else begin
         score_sat = 32'sh7fff_ffff;
      end
   end

   assign rsp_score         = score_ff;
   assign rsp_predict_taken = !score_ff[31];

endmodule

// ===== rtl/mlp_branch_predictor.sv =====
// Perceptron-style branch predictor with one hidden layer. Predict beats walk the hidden
// neurons one per cycle: each neuron's row of history weights is read from per-bit RAMs,
// summed through a registered two-level masked adder tree, passed through the sigmoid ROM
// and multiplied by its output weight, then accumulated. A predict runs the neuron walk
// and then drains the five-stage read/sum/multiply/accumulate pipeline; history updates
// and weight writes are done from the idle state, so the next beat can follow. Only one
// beat is processed at a time; a finished result waits in the output register while the
// next beat is accepted. Weight stores hold no defined value until written.
module mlp_branch_predictor #(
   parameter int MAX_HISTORY = mbp_pkg::MAX_HISTORY_DEF,
   parameter int MAX_HIDDEN  = mbp_pkg::MAX_HIDDEN_DEF,
   parameter int WEIGHT_BITS = mbp_pkg::WEIGHT_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [2:0]                        req_opcode,
   input  logic                              req_taken,
   input  logic [3:0]                        req_neuron,
   input  logic [5:0]                        req_input_index,
   input  logic signed [15:0]                req_weight_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_predict_taken,
   output logic signed [31:0]                rsp_score,
   input  logic                              csr_we,
   input  logic [mbp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [mbp_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import mbp_pkg::*;

   cmd_type    cmd;
   status_type stat;

   mbp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_opcode (req_opcode),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .cmd        (cmd),
      .stat       (stat)
   );

   mbp_datapath #(
      .MAX_HISTORY (MAX_HISTORY),
      .MAX_HIDDEN  (MAX_HIDDEN),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_taken         (req_taken),
      .req_neuron        (req_neuron),
      .req_input_index   (req_input_index),
      .req_weight_value  (req_weight_value),
      .rsp_predict_taken (rsp_predict_taken),
      .rsp_score         (rsp_score)
   );

`ifndef SYNTH
   a_finish_drained: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !stat.busy)
      else $error("result loaded while neuron pipeline busy");

   a_predict_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_opcode == OP_PREDICT) |=> req_stall)
      else $error("predict beat did not hold off input");

   a_sign_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_predict_taken == !rsp_score[31]))
      else $error("prediction disagrees with score sign");

   a_issue_running: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> req_stall)
      else $error("neuron issued while input open");
`endif

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import mbp_pkg::*;

   typedef struct {
      logic [2:0]         op;
      logic               taken;
      logic [3:0]         neuron;
      logic [5:0]         idx;
      logic signed [15:0] wv;
   } branch_op_type;

   typedef struct {
      logic               taken;
      logic signed [31:0] score;
   } prediction_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [2:0] req_opcode = 0;
   logic req_taken = 0;
   logic [3:0] req_neuron = 0;
   logic [5:0] req_input_index = 0;
   logic signed [15:0] req_weight_value = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic rsp_predict_taken;
   logic signed [31:0] rsp_score;
   logic csr_we = 0;
   logic [CSR_INDEX_W-1:0] csr_index = 0;
   logic [CSR_DATA_W-1:0] csr_wdata = 0;

   mlp_branch_predictor uut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // predictor state
   logic [63:0] ghist;
   logic signed [15:0] hid_w [16][64];
   logic signed [15:0] hid_b [16];
   logic signed [15:0] out_w [16];
   logic [6:0] hist_len;
   logic [4:0] hid_cnt;
   logic signed [31:0] out_bias;

   branch_op_type pending_ops[$];
   prediction_type expected_preds[$];
   int errors = 0;
   bit req_fire = 0;
   bit calm = 0;
   int req_gap = 0;
   int rsp_gap = 0;

   function automatic int eff_len();
      if (hist_len < 1) return 1;
      if (hist_len > 64) return 64;
      return hist_len;
   endfunction

   function automatic prediction_type compute_prediction();
      prediction_type p;
      longint acc, s;
      int hc, hl;
      hc = (hid_cnt < 1) ? 1 : (hid_cnt > 16) ? 16 : hid_cnt;
      hl = eff_len();
      acc = out_bias;
      for (int n = 0; n < hc; n++) begin
         s = hid_b[n];
         for (int j = 0; j < hl; j++)
            if (ghist[j]) s += hid_w[n][j];
         if (s < -2048) s = -2048;
         if (s > 2047) s = 2047;
         acc += longint'(SIG_ROM[(s + 2048) >> 4]) * longint'(out_w[n]);
      end
      if (acc > 64'sd2147483647) acc = 64'sd2147483647;
      if (acc < -64'sd2147483648) acc = -64'sd2147483648;
      p.taken = (acc >= 0);
      p.score = acc[31:0];
      return p;
   endfunction

   task automatic apply_op(branch_op_type b);
      logic [63:0] mask;
      case (b.op)
         OP_PREDICT: expected_preds = {expected_preds, compute_prediction()};
         OP_HIST_UPD: begin
            mask = (eff_len() >= 64) ? '1 : ((64'd1 << eff_len()) - 64'd1);
            ghist = ((ghist << 1) | 64'(b.taken)) & mask;
         end
         OP_WR_HWEIGHT: hid_w[b.neuron][b.idx] = b.wv;
         OP_WR_HBIAS: hid_b[b.neuron] = b.wv;
         OP_WR_OWEIGHT: out_w[b.neuron] = b.wv;
         default: ;
      endcase
   endtask

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
   endtask

   // monitor
   always @(posedge clock) begin
      prediction_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_preds.size() == 0) report("unexpected beat", '0, '0);
         else begin
            e = expected_preds.pop_front();
            if (rsp_predict_taken !== e.taken)
               report("predict_taken", 32'(rsp_predict_taken), 32'(e.taken));
            if (rsp_score !== e.score) report("score", rsp_score, e.score);
         end
      end
      req_fire = !reset && req_valid && !req_stall;
      if (req_fire) begin
         branch_op_type b;
         b.op = req_opcode; b.taken = req_taken; b.neuron = req_neuron;
         b.idx = req_input_index; b.wv = req_weight_value;
         apply_op(b);
      end
   end

   // driver
   always @(negedge clock) begin
      branch_op_type b;
      if (!reset && (!req_valid || req_fire)) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 0;
         end else if (!calm && $urandom_range(0, 19) == 0) begin
            req_gap = $urandom_range(0, 14);
            req_valid <= 0;
         end else if (pending_ops.size() > 0) begin
            b = pending_ops.pop_front();
            req_valid <= 1;
            req_opcode <= b.op; req_taken <= b.taken; req_neuron <= b.neuron;
            req_input_index <= b.idx; req_weight_value <= b.wv;
         end else req_valid <= 0;
      end
      if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_stall <= 1;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
         rsp_gap = $urandom_range(0, 14);
         rsp_stall <= 1;
      end else rsp_stall <= 0;
   end

   function automatic logic signed [15:0] rand_weight();
      if ($urandom_range(0, 1) != 0) return 16'(int'($urandom_range(0, 400)) - 200);
      return 16'($urandom());
   endfunction

   function automatic branch_op_type mk(logic [2:0] op, logic t, logic [3:0] n, logic [5:0] i,
                                        logic signed [15:0] w);
      branch_op_type b;
      b.op = op; b.taken = t; b.neuron = n; b.idx = i; b.wv = w;
      return b;
   endfunction

   function automatic void add_op(branch_op_type b);
      pending_ops = {pending_ops, b};
   endfunction

   function automatic branch_op_type rand_op();
      branch_op_type b;
      int r;
      b = mk(3'($urandom()), 1'($urandom()), 4'($urandom()), 6'($urandom()), rand_weight());
      r = $urandom_range(0, 99);
      if (r < 35) b.op = OP_PREDICT;
      else if (r < 70) b.op = OP_HIST_UPD;
      else if (r < 82) b.op = OP_WR_HWEIGHT;
      else if (r < 88) b.op = OP_WR_HBIAS;
      else if (r < 94) b.op = OP_WR_OWEIGHT;
      else b.op = 3'($urandom_range(5, 7));
      return b;
   endfunction

   task automatic wait_idle();
      while (pending_ops.size() != 0 || req_valid || expected_preds.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic csr_write(csr_index_type i, logic [31:0] d);
      @(negedge clock);
      csr_we <= 1; csr_index <= i; csr_wdata <= d;
      case (i)
         CSR_HIST_LEN: hist_len = d[6:0];
         CSR_HIDDEN_CNT: hid_cnt = d[4:0];
         default: out_bias = d;
      endcase
      @(negedge clock);
      csr_we <= 0;
   endtask

   initial begin
      logic [6:0] lens[5] = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd33};
      logic [4:0] cnts[5] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5};
      logic [31:0] biases[5];
      branch_op_type b;
      int upd_cap;
      int upd;
      biases = '{32'h8000_0000, 32'h7FFF_FFFF, 32'd0, $urandom(), $urandom()};
      ghist = 0; hist_len = 64; hid_cnt = 16; out_bias = 0;
      repeat (11) @(posedge clock);
      reset <= 0;

      // this loop loads only the low sixteen history positions; history is kept inside them
      for (int n = 0; n < 16; n++) begin
         for (int j = 0; j < 16; j++)
            add_op(mk(OP_WR_HWEIGHT, 1'b0, 4'(n), 6'(j), rand_weight()));
         add_op(mk(OP_WR_HBIAS, 1'b0, 4'(n), 6'd0, rand_weight()));
         add_op(mk(OP_WR_OWEIGHT, 1'b0, 4'(n), 6'd0, rand_weight()));
      end
      // directed: extremes, every opcode, unused opcodes
      add_op(mk(OP_PREDICT, 1'b0, 4'd0, 6'd0, 16'sd0));
      add_op(mk(OP_WR_HBIAS, 1'b0, 4'd15, 6'd0, 16'sh7FFF));
      add_op(mk(OP_WR_HBIAS, 1'b0, 4'd0, 6'd0, -16'sh8000));
      add_op(mk(OP_WR_OWEIGHT, 1'b0, 4'd15, 6'd0, 16'sh7FFF));
      add_op(mk(OP_WR_OWEIGHT, 1'b0, 4'd0, 6'd0, -16'sh8000));
      add_op(mk(OP_PREDICT, 1'b1, 4'd15, 6'd63, 16'shFFFF));
      add_op(mk(OP_WR_HWEIGHT, 1'b1, 4'd15, 6'd63, 16'sh7FFF));
      add_op(mk(OP_WR_HWEIGHT, 1'b0, 4'd0, 6'd0, -16'sh8000));
      for (int k = 0; k < 8; k++) add_op(mk(OP_HIST_UPD, 1'b1, 4'd0, 6'd0, 16'sd0));
      add_op(mk(OP_PREDICT, 1'b0, 4'd0, 6'd0, 16'sd0));
      add_op(mk(OP_HIST_UPD, 1'b0, 4'd15, 6'd63, 16'shFFFF));
      add_op(mk(3'd5, 1'b1, 4'd15, 6'd63, 16'sh7FFF));
      add_op(mk(3'd6, 1'b0, 4'd0, 6'd0, 16'sd0));
      add_op(mk(3'd7, 1'b1, 4'd15, 6'd63, -16'sh8000));
      add_op(mk(OP_PREDICT, 1'b0, 4'd0, 6'd0, 16'sd0));

      for (int ph = 0; ph < 5; ph++) begin
         upd_cap = (lens[ph] > 7'd16) ? 16 : 1000;
         upd = 0;
         // clear history through a one-bit length
         wait_idle();
         csr_write(CSR_HIST_LEN, 32'd1);
         add_op(mk(OP_HIST_UPD, 1'b0, 4'd0, 6'd0, 16'sd0));
         wait_idle();
         csr_write(CSR_HIST_LEN, 32'(lens[ph]));
         csr_write(CSR_HIDDEN_CNT, 32'(cnts[ph]));
         csr_write(CSR_OUT_BIAS, biases[ph]);
         if (ph == 4) calm = 1;
         // long history lengths get at most sixteen updates
         for (int k = 0; k < 66; k++) begin
            b = rand_op();
            if (b.op == OP_HIST_UPD) begin
               if (upd < upd_cap) upd++;
               else b.op = OP_PREDICT;
            end
            add_op(b);
         end
         add_op(mk(OP_PREDICT, 1'b0, 4'd0, 6'd0, 16'sd0));
      end

      wait_idle();
      if (errors == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end
endmodule
